// ===== rtl/bpc_pkg.sv =====
`default_nettype none

package bpc_pkg;

  // Field widths
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int PRES_W  = 19;
  localparam int TEMP_W  = 16;
  localparam int CIDX_W  = 3;

  // Pipeline depth
  localparam int NSTG    = 9;

  // Internal widths
  localparam int DT_W    = 25;  // raw temperature minus reference
  localparam int PROD_W  = 42;  // dT times a calibration word
  localparam int DTSQ_W  = 50;  // dT squared
  localparam int T2_W    = 17;
  localparam int A_W     = 19;  // TEMP - 2000 and TEMP + 1500
  localparam int TW_W    = 20;  // temperature before saturation
  localparam int OS_W    = 40;  // OFF and SENS
  localparam int SQ_W    = 38;
  localparam int COR_W   = 46;  // OFF2, SENS2 and corrected OFF
  localparam int SC_W    = 41;  // corrected SENS
  localparam int PL_W    = 45;  // partial products of raw pressure times SENS
  localparam int Q_W     = 48;

  // Constants of the scheme
  localparam logic signed [TW_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [A_W-1:0]  VLOW_OFS  = 19'sd3500;  // 2000 - (-1500)
  localparam logic [COR_W-1:0]       OFF2_A_K  = 46'd61;
  localparam logic [COR_W-1:0]       OFF2_B_K  = 46'd15;

  localparam logic signed [TW_W-1:0] TEMP_MAX  = 20'sd32767;
  localparam logic signed [TW_W-1:0] TEMP_MIN  = -20'sd32768;
  localparam logic signed [32:0]     PRES_MAX  = 33'sd262143;
  localparam logic signed [32:0]     PRES_MIN  = -33'sd262144;

  typedef enum logic [CIDX_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFFSET_TC = 3'd3,
    REG_TREF      = 3'd4,
    REG_TEMP_TC   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] sens_coeff;
    logic [CAL_W-1:0] offset_coeff;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] ref_temperature;
    logic [CAL_W-1:0] temp_coeff;
  } cal_t;

endpackage

`default_nettype wire

// ===== rtl/barometric_pressure_compensation_core.sv =====
`default_nettype none

// Second-order barometric compensation. Each transfer of a raw pressure and raw
// temperature reading yields one compensated pressure (0.01 mbar, saturated to
// 19 bits signed) and temperature (0.01 C, saturated to 16 bits signed). The
// datapath is a nine-stage pipeline: a new reading is taken every cycle while
// out_ready stays high. When a result is held at the output the whole pipeline
// stalls with it, so in_ready follows out_ready whenever the output register is
// full. The user writes calibration words through the cfg port only while the
// pipeline is empty; the block does not check this. cfg_ready is always high.
module barometric_pressure_compensation_core
  import bpc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [RAW_W-1:0]         in_raw_pressure,
  input  wire logic [RAW_W-1:0]         in_raw_temperature,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [PRES_W-1:0]      out_pressure,
  output logic signed [TEMP_W-1:0]      out_temperature,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CIDX_W-1:0]        cfg_index,
  input  wire logic [CAL_W-1:0]         cfg_data
);

  cal_t cal;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic            en;

  assign en        = !v_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[NSTG-1];
  assign v_nxt     = {v_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // Stage 1: dT
  logic signed [DT_W-1:0]   s1_dt_r, s1_dt_nxt;
  logic [RAW_W-1:0]         s1_d1_r;
  // Stage 2: products with dT
  logic signed [PROD_W-1:0] s2_pt_r, s2_po_r, s2_ps_r;
  logic signed [PROD_W-1:0] s2_pt_nxt, s2_po_nxt, s2_ps_nxt;
  logic signed [DTSQ_W-1:0] s2_dtsq_r, s2_dtsq_nxt;
  logic [RAW_W-1:0]         s2_d1_r;
  // Stage 3: TEMP offsets, OFF, SENS, T2
  logic signed [A_W-1:0]    s3_a_r, s3_b_r, s3_a_nxt, s3_b_nxt;
  logic signed [OS_W-1:0]   s3_off_r, s3_sens_r, s3_off_nxt, s3_sens_nxt;
  logic [T2_W-1:0]          s3_t2_r;
  logic [RAW_W-1:0]         s3_d1_r;
  // Stage 4: squares, final temperature
  logic signed [SQ_W-1:0]   s4_asq_r, s4_bsq_r, s4_asq_nxt, s4_bsq_nxt;
  logic                     s4_lo_r, s4_vlo_r;
  logic signed [TEMP_W-1:0] s4_t_r, s4_t_nxt;
  logic signed [TW_W-1:0]   s4_tw;
  logic signed [OS_W-1:0]   s4_off_r, s4_sens_r;
  logic [RAW_W-1:0]         s4_d1_r;
  // Stage 5: OFF2, SENS2
  logic [COR_W-1:0]         s5_off2_r, s5_sens2_r, s5_off2_nxt, s5_sens2_nxt;
  logic [COR_W-1:0]         s5_ea, s5_eb;
  logic signed [TEMP_W-1:0] s5_t_r;
  logic signed [OS_W-1:0]   s5_off_r, s5_sens_r;
  logic [RAW_W-1:0]         s5_d1_r;
  // Stage 6: corrected OFF and SENS
  logic signed [COR_W-1:0]  s6_offc_r, s6_offc_nxt;
  logic signed [SC_W-1:0]   s6_sensc_r, s6_sensc_nxt;
  logic signed [TEMP_W-1:0] s6_t_r;
  logic [RAW_W-1:0]         s6_d1_r;
  // Stage 7: partial products of raw pressure times SENS
  logic [PL_W-1:0]          s7_pl_r, s7_pl_nxt;
  logic signed [PL_W-1:0]   s7_ph_r, s7_ph_nxt;
  logic signed [COR_W-1:0]  s7_offc_r;
  logic signed [TEMP_W-1:0] s7_t_r;
  // Stage 8: floor(D1*SENS / 2^21) - OFF
  logic signed [Q_W-1:0]    s8_q_r, s8_q_nxt;
  logic signed [TEMP_W-1:0] s8_t_r;
  // Stage 9: output register
  logic signed [PRES_W-1:0] s9_p_r, s9_p_nxt;
  logic signed [TEMP_W-1:0] s9_t_r;
  logic signed [32:0]       s9_pv;

  always_comb begin
    s1_dt_nxt = $signed({1'b0, in_raw_temperature})
              - $signed({1'b0, cal.ref_temperature, 8'b0});

    s2_pt_nxt   = s1_dt_r * $signed({1'b0, cal.temp_coeff});
    s2_po_nxt   = s1_dt_r * $signed({1'b0, cal.offset_temp_coeff});
    s2_ps_nxt   = s1_dt_r * $signed({1'b0, cal.sens_temp_coeff});
    s2_dtsq_nxt = s1_dt_r * s1_dt_r;

    // Arithmetic shifts floor toward minus infinity
    s3_a_nxt    = s2_pt_r[PROD_W-1:23];
    s3_b_nxt    = s3_a_nxt + VLOW_OFS;
    s3_off_nxt  = $signed({7'b0, cal.offset_coeff, 17'b0})
                + $signed({{4{s2_po_r[PROD_W-1]}}, s2_po_r[PROD_W-1:6]});
    s3_sens_nxt = $signed({8'b0, cal.sens_coeff, 16'b0})
                + $signed({{5{s2_ps_r[PROD_W-1]}}, s2_ps_r[PROD_W-1:7]});

    s4_asq_nxt = s3_a_r * s3_a_r;
    s4_bsq_nxt = s3_b_r * s3_b_r;
    s4_tw = $signed({s3_a_r[A_W-1], s3_a_r}) + TEMP_REF
          - (s3_a_r[A_W-1] ? $signed({3'b0, s3_t2_r}) : 20'sd0);
    if (s4_tw > TEMP_MAX) begin
      s4_t_nxt = TEMP_MAX[TEMP_W-1:0];
    end else if (s4_tw < TEMP_MIN) begin
      s4_t_nxt = TEMP_MIN[TEMP_W-1:0];
    end else begin
      s4_t_nxt = s4_tw[TEMP_W-1:0];
    end

    // Squares are never negative
    s5_ea = {8'b0, s4_asq_r};
    s5_eb = {8'b0, s4_bsq_r};
    s5_off2_nxt  = '0;
    s5_sens2_nxt = '0;
    if (s4_lo_r) begin
      s5_off2_nxt  = ((s5_ea * OFF2_A_K) >> 4)
                   + (s4_vlo_r ? s5_eb * OFF2_B_K : '0);
      s5_sens2_nxt = (s5_ea << 1) + (s4_vlo_r ? (s5_eb << 3) : '0);
    end

    s6_offc_nxt  = $signed({{6{s5_off_r[OS_W-1]}}, s5_off_r}) - $signed(s5_off2_r);
    s6_sensc_nxt = $signed({s5_sens_r[OS_W-1], s5_sens_r})
                 - $signed({3'b0, s5_sens2_r[37:0]});

    // Split SENS into a signed upper part and an unsigned lower 21 bits
    s7_pl_nxt = PL_W'(s6_d1_r) * PL_W'(s6_sensc_r[20:0]);
    s7_ph_nxt = $signed({1'b0, s6_d1_r}) * $signed(s6_sensc_r[SC_W-1:21]);

    s8_q_nxt = $signed({{3{s7_ph_r[PL_W-1]}}, s7_ph_r})
             + $signed({24'b0, s7_pl_r[PL_W-1:21]})
             - $signed({{2{s7_offc_r[COR_W-1]}}, s7_offc_r});

    s9_pv = s8_q_r[Q_W-1:15];
    if (s9_pv > PRES_MAX) begin
      s9_p_nxt = PRES_MAX[PRES_W-1:0];
    end else if (s9_pv < PRES_MIN) begin
      s9_p_nxt = PRES_MIN[PRES_W-1:0];
    end else begin
      s9_p_nxt = s9_pv[PRES_W-1:0];
    end
  end

  // Payload advances with the valid bits and holds on a stall
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dt_r    <= s1_dt_nxt;
      s1_d1_r    <= in_raw_pressure;

      s2_pt_r    <= s2_pt_nxt;
      s2_po_r    <= s2_po_nxt;
      s2_ps_r    <= s2_ps_nxt;
      s2_dtsq_r  <= s2_dtsq_nxt;
      s2_d1_r    <= s1_d1_r;

      s3_a_r     <= s3_a_nxt;
      s3_b_r     <= s3_b_nxt;
      s3_off_r   <= s3_off_nxt;
      s3_sens_r  <= s3_sens_nxt;
      s3_t2_r    <= s2_dtsq_r[47:31];
      s3_d1_r    <= s2_d1_r;

      s4_asq_r   <= s4_asq_nxt;
      s4_bsq_r   <= s4_bsq_nxt;
      s4_lo_r    <= s3_a_r[A_W-1];
      s4_vlo_r   <= s3_b_r[A_W-1];
      s4_t_r     <= s4_t_nxt;
      s4_off_r   <= s3_off_r;
      s4_sens_r  <= s3_sens_r;
      s4_d1_r    <= s3_d1_r;

      s5_off2_r  <= s5_off2_nxt;
      s5_sens2_r <= s5_sens2_nxt;
      s5_t_r     <= s4_t_r;
      s5_off_r   <= s4_off_r;
      s5_sens_r  <= s4_sens_r;
      s5_d1_r    <= s4_d1_r;

      s6_offc_r  <= s6_offc_nxt;
      s6_sensc_r <= s6_sensc_nxt;
      s6_t_r     <= s5_t_r;
      s6_d1_r    <= s5_d1_r;

      s7_pl_r    <= s7_pl_nxt;
      s7_ph_r    <= s7_ph_nxt;
      s7_offc_r  <= s6_offc_r;
      s7_t_r     <= s6_t_r;

      s8_q_r     <= s8_q_nxt;
      s8_t_r     <= s7_t_r;

      s9_p_r     <= s9_p_nxt;
      s9_t_r     <= s8_t_r;
    end
  end

  assign out_pressure    = s9_p_r;
  assign out_temperature = s9_t_r;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted item did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(v_r))
    else $error("pipeline valid bits moved during a stall");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-1] && !out_ready |-> !in_ready)
    else $error("input taken while the output register is held");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> !v_r[0])
    else $error("first stage valid without a transfer");
`endif

endmodule

`default_nettype wire

// ===== rtl/bpc_cfg.sv =====
`default_nettype none

module bpc_cfg
  import bpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]  cfg_data,
  output cal_t                   cal
);

  cal_t cal_r;
  cal_t cal_nxt;

  assign cfg_ready = 1'b1;
  assign cal       = cal_r;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SENS:      cal_nxt.sens_coeff        = cfg_data;
        REG_OFFSET:    cal_nxt.offset_coeff      = cfg_data;
        REG_SENS_TC:   cal_nxt.sens_temp_coeff   = cfg_data;
        REG_OFFSET_TC: cal_nxt.offset_temp_coeff = cfg_data;
        REG_TREF:      cal_nxt.ref_temperature   = cfg_data;
        REG_TEMP_TC:   cal_nxt.temp_coeff        = cfg_data;
        default:       cal_nxt = cal_r;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

endmodule

`default_nettype wire
